// ===== rtl/mfs_pkg.sv =====
// Types and constants shared by the motor fault supervisor modules.
package mfs_pkg;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam int FAULT_W = 6;

  localparam logic [FAULT_W-1:0] F_OVERCURRENT = 6'h01;
  localparam logic [FAULT_W-1:0] F_OVERSPEED   = 6'h02;
  localparam logic [FAULT_W-1:0] F_LOWBATT     = 6'h04;
  localparam logic [FAULT_W-1:0] F_OVERVOLT    = 6'h08;
  localparam logic [FAULT_W-1:0] F_COMMS       = 6'h10;
  localparam logic [FAULT_W-1:0] F_STALL       = 6'h20;

  // |speed| below one rpm, in sixteenths of rpm
  localparam logic [19:0] STILL_LIMIT = 20'd16;

  typedef enum logic [2:0] {
    CFG_MAX_CURRENT   = 3'd0,
    CFG_OC_HOLD       = 3'd1,
    CFG_MAX_SPEED     = 3'd2,
    CFG_MIN_BATT      = 3'd3,
    CFG_MAX_BATT      = 3'd4,
    CFG_WATCHDOG      = 3'd5,
    CFG_STALL_PWM     = 3'd6,
    CFG_STALL_TIMEOUT = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] RST_MAX_CURRENT   = 16'd3000;
  localparam logic [15:0] RST_OC_HOLD       = 16'd10;
  localparam logic [18:0] RST_MAX_SPEED     = 19'd96000;
  localparam logic [15:0] RST_MIN_BATT      = 16'd10500;
  localparam logic [15:0] RST_MAX_BATT      = 16'd13500;
  localparam logic [31:0] RST_WATCHDOG      = 32'd500;
  localparam logic [15:0] RST_STALL_PWM     = 16'd200;
  localparam logic [31:0] RST_STALL_TIMEOUT = 32'd1000;

  typedef struct packed {
    logic               req_type;
    logic signed [19:0] speed;
    logic signed [15:0] motor_ma;
    logic [15:0]        batt_mv;
    logic [15:0]        duty;
    logic [31:0]        last_cmd_time;
    logic [31:0]        now_time;
  } in_item_t;

  typedef struct packed {
    logic [FAULT_W-1:0] fault_flags;
    logic               safe;
    logic               estop_pulse;
    logic               fault_led;
  } out_item_t;

  typedef struct packed {
    logic [15:0] max_motor_ma;
    logic [15:0] overcurrent_hold_ticks;
    logic [18:0] max_speed;
    logic [15:0] min_batt_mv;
    logic [15:0] max_batt_mv;
    logic [31:0] watchdog_ms;
    logic [15:0] stall_pwm_limit;
    logic [31:0] stall_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [FAULT_W-1:0] latched_faults;
    logic [15:0]        overcurrent_count;
    logic [31:0]        stall_count;
    logic [31:0]        start_stamp;
    logic               start_taken;
  } state_t;

endpackage

// ===== rtl/mfs_eval.sv =====
// Per-item fault evaluation: next supervisor state and the result item.
module mfs_eval #(
  parameter int unsigned STARTUP_GRACE_MS = 100
) (
  input  mfs_pkg::in_item_t  item,
  input  mfs_pkg::state_t    state,
  input  mfs_pkg::cfg_t      cfg,
  output mfs_pkg::state_t    state_next,
  output mfs_pkg::out_item_t result
);

  logic [31:0] stamp;
  logic [31:0] since_cmd;
  logic [31:0] elapsed;
  logic        in_grace;
  logic        comms_ok;
  logic        comms_lost;
  logic [19:0] mag;
  logic        oc_cond;
  logic        stall_cond;
  logic [15:0] oc_inc;
  logic [31:0] st_inc;
  logic [mfs_pkg::FAULT_W-1:0] nf;
  logic        pulse;

  assign stamp      = state.start_taken ? state.start_stamp : item.now_time;
  assign since_cmd  = item.now_time - item.last_cmd_time;
  assign elapsed    = item.now_time - stamp;
  assign in_grace   = elapsed < 32'(STARTUP_GRACE_MS);
  assign comms_ok   = (item.last_cmd_time != 32'd0) && (since_cmd <= cfg.watchdog_ms);
  assign comms_lost = (item.last_cmd_time != 32'd0) && (since_cmd > cfg.watchdog_ms);

  // -(-2^19) wraps to 2^19, which reads correctly as unsigned
  assign mag = item.speed[19] ? 20'(-item.speed) : 20'(item.speed);

  assign oc_cond = (item.duty != 16'd0) &&
                   ($signed({item.motor_ma[15], item.motor_ma}) >
                    $signed({1'b0, cfg.max_motor_ma}));
  assign stall_cond = (item.duty > cfg.stall_pwm_limit) && (mag < mfs_pkg::STILL_LIMIT);

  assign oc_inc = (state.overcurrent_count == 16'hFFFF) ? state.overcurrent_count
                                                        : state.overcurrent_count + 16'd1;
  assign st_inc = (state.stall_count == 32'hFFFF_FFFF) ? state.stall_count
                                                       : state.stall_count + 32'd1;

  always_comb begin
    nf = '0;
    if (oc_cond && (oc_inc >= cfg.overcurrent_hold_ticks)) nf = nf | mfs_pkg::F_OVERCURRENT;
    if (mag > {1'b0, cfg.max_speed})                       nf = nf | mfs_pkg::F_OVERSPEED;
    if (item.batt_mv < cfg.min_batt_mv)                    nf = nf | mfs_pkg::F_LOWBATT;
    if (item.batt_mv > cfg.max_batt_mv)                    nf = nf | mfs_pkg::F_OVERVOLT;
    if (comms_lost)                                        nf = nf | mfs_pkg::F_COMMS;
    if (stall_cond && (st_inc >= cfg.stall_timeout_ticks)) nf = nf | mfs_pkg::F_STALL;
  end

  always_comb begin
    state_next = state;
    pulse      = 1'b0;
    if (item.req_type == mfs_pkg::REQ_CLEAR) begin
      state_next.latched_faults    = '0;
      state_next.overcurrent_count = '0;
      state_next.stall_count       = '0;
    end else begin
      state_next.start_stamp = stamp;
      state_next.start_taken = 1'b1;
      if (state.latched_faults != '0) begin
        if ((state.latched_faults == mfs_pkg::F_COMMS) && comms_ok) begin
          state_next.latched_faults = '0;
        end
      end else if (!in_grace) begin
        state_next.overcurrent_count = oc_cond ? oc_inc : 16'd0;
        state_next.stall_count       = stall_cond ? st_inc : 32'd0;
        state_next.latched_faults    = nf;
        pulse                        = (nf != '0);
      end
    end
  end

  always_comb begin
    result.fault_flags = state_next.latched_faults;
    result.safe        = (state_next.latched_faults == '0);
    result.estop_pulse = pulse;
    result.fault_led   = (state_next.latched_faults != '0);
  end

endmodule

// ===== rtl/motor_fault_supervisor_top.sv =====
// Motor fault supervisor top level: channels, configuration and state registers.
//
// Usage:
//   in channel  (in_valid / in_stall / in_item): one item per millisecond tick, or a
//     clear command (req_type = 1). Accepted when in_valid is high and in_stall low.
//   out channel (out_valid / out_stall / out_item): one result item per input item,
//     in order, holding fault flags, safe, estop pulse and LED level.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//     always ready; write only while no item is in flight.
// Path: an accepted item is held in the input register, and its result then moves to
//   the result register when out_stall lets it advance, which raises out_valid.
//   Throughput: one item per cycle while the output is not stalled; the fault evaluation
//   and the counter updates sit in one short combinational pass between the two registers.
// Stalling: while out_stall holds a result, one more item is taken into the input
//   register; after that in_stall rises until the result is taken.
// Reset: rst (synchronous) restores default limits, clears latched faults, both
//   counters and the start stamp; the first tick afterwards takes the stamp that
//   opens the start-up grace window of STARTUP_GRACE_MS milliseconds.
module motor_fault_supervisor_top #(
  parameter int unsigned STARTUP_GRACE_MS = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mfs_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic               s1_valid;
  mfs_pkg::in_item_t  s1_item;
  mfs_pkg::state_t    state;
  mfs_pkg::state_t    state_next;
  mfs_pkg::cfg_t      cfg;
  mfs_pkg::out_item_t result;
  logic               advance;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  mfs_eval #(
    .STARTUP_GRACE_MS(STARTUP_GRACE_MS)
  ) u_eval (
    .item      (s1_item),
    .state     (state),
    .cfg       (cfg),
    .state_next(state_next),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_motor_ma           <= mfs_pkg::RST_MAX_CURRENT;
      cfg.overcurrent_hold_ticks <= mfs_pkg::RST_OC_HOLD;
      cfg.max_speed              <= mfs_pkg::RST_MAX_SPEED;
      cfg.min_batt_mv            <= mfs_pkg::RST_MIN_BATT;
      cfg.max_batt_mv            <= mfs_pkg::RST_MAX_BATT;
      cfg.watchdog_ms            <= mfs_pkg::RST_WATCHDOG;
      cfg.stall_pwm_limit        <= mfs_pkg::RST_STALL_PWM;
      cfg.stall_timeout_ticks    <= mfs_pkg::RST_STALL_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (mfs_pkg::cfg_idx_t'(cfg_index))
        mfs_pkg::CFG_MAX_CURRENT:   cfg.max_motor_ma           <= cfg_data[15:0];
        mfs_pkg::CFG_OC_HOLD:       cfg.overcurrent_hold_ticks <= cfg_data[15:0];
        mfs_pkg::CFG_MAX_SPEED:     cfg.max_speed              <= cfg_data[18:0];
        mfs_pkg::CFG_MIN_BATT:      cfg.min_batt_mv            <= cfg_data[15:0];
        mfs_pkg::CFG_MAX_BATT:      cfg.max_batt_mv            <= cfg_data[15:0];
        mfs_pkg::CFG_WATCHDOG:      cfg.watchdog_ms            <= cfg_data;
        mfs_pkg::CFG_STALL_PWM:     cfg.stall_pwm_limit        <= cfg_data[15:0];
        mfs_pkg::CFG_STALL_TIMEOUT: cfg.stall_timeout_ticks    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while a stage was free");

  a_clear_empties_state: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.req_type == mfs_pkg::REQ_CLEAR) |=>
      (state.latched_faults == '0 && state.overcurrent_count == '0 &&
       state.stall_count == '0))
    else $error("clear item left faults or counters set");

  a_pulse_has_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.estop_pulse) |-> (out_item.fault_flags != '0))
    else $error("estop pulse without a latched fault");

  a_safe_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.safe == (out_item.fault_flags == '0)) &&
                   (out_item.fault_led != out_item.safe)))
    else $error("safe or LED disagrees with fault flags");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("supervisor state changed without an item");

endmodule
